// File: rtl/core/rhd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared constants, types and the saturation vapor pressure table.
// ----------------------------------------------------------------------------
package rhd_pkg;

  // Table geometry and value formats.
  localparam int TableEntries = 41;
  localparam int PosFracBits  = 16;
  localparam int PosWidth     = 22;
  localparam int IdxWidth     = 6;
  localparam int SvpWidth     = 34;
  localparam int DiffWidth    = 32;
  localparam int TempWidth    = 16;
  localparam int RatioWidth   = 16;
  localparam int QuotBits     = 15;

  // Q1.15 value for 1.0.
  localparam logic [RatioWidth-1:0] OneQ15 = 16'h8000;

  typedef logic [SvpWidth-1:0] svp_t;
  typedef svp_t svp_rom_t [TableEntries];

  // Table values in millionths of a hectopascal.
  localparam longint unsigned SvpMicro [TableEntries] = '{
    64'd34,        64'd89,        64'd220,       64'd517,       64'd1155,
    64'd2472,      64'd5080,      64'd10050,     64'd19210,     64'd35530,
    64'd63560,     64'd111100,    64'd189100,    64'd313900,    64'd508800,
    64'd807000,    64'd1254000,   64'd1911800,   64'd2862700,   64'd4214800,
    64'd6107800,   64'd8719200,   64'd12272000,  64'd17044000,  64'd23373000,
    64'd31671000,  64'd42430000,  64'd56236000,  64'd73777000,  64'd95855000,
    64'd123400000, 64'd157460000, 64'd199260000, 64'd250160000, 64'd311690000,
    64'd385560000, 64'd473670000, 64'd578090000, 64'd701130000, 64'd845280000,
    64'd1013250000
  };

  // Converts the table to unsigned Q10.24 with rounding, at elaboration.
  function automatic svp_rom_t build_svp_rom();
    svp_rom_t   rom;
    logic [63:0] v;
    for (int i = 0; i < TableEntries; i++) begin
      v      = ((SvpMicro[i] << 24) + 64'd500000) / 64'd1000000;
      rom[i] = v[SvpWidth-1:0];
    end
    return rom;
  endfunction

  localparam svp_rom_t SvpRom = build_svp_rom();

  // Status that travels with each item alongside the arithmetic.
  typedef struct packed {
    logic both_ok;
    logic saturated;
  } rhd_tag_t;

endpackage
`default_nettype wire

// File: rtl/core/rhd_svp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhd_svp
// Five-stage pipeline from a temperature to its interpolated saturation vapor
// pressure in Q10.24.
// ----------------------------------------------------------------------------
module rhd_svp
  import rhd_pkg::*;
#(
  parameter int TEMP_FRAC_BITS = 7
) (
  input  wire logic                 clk_i,
  input  wire logic [TempWidth-1:0] temp_i,
  output logic      [SvpWidth-1:0]  svp_o
);

  localparam int Shift = PosFracBits - TEMP_FRAC_BITS;
  localparam int XWidth   = 24;
  localparam int XFull    = TempWidth + PosFracBits;
  // The offset can exceed the temperature range at fine fraction formats.
  localparam logic [XFull-1:0] Offset =
    XFull'(((17316 << TEMP_FRAC_BITS) + 50) / 100);
  // Scaled distance that maps onto the top table position 39.0.
  localparam logic [XWidth-1:0] XMax = XWidth'(195 << PosFracBits);
  // Reciprocal of five for exact division of values below 2^24.
  localparam int RecipShift = 27;
  localparam logic [24:0] Recip = 25'(((64'd1 << RecipShift) + 64'd4) / 64'd5);

  logic [XWidth-1:0]     x_d, x_q;
  logic [PosWidth-1:0]   pos_q;
  logic [SvpWidth-1:0]   lo_q, base_q, svp_q;
  logic [DiffWidth-1:0]  diff_q, step_q;
  logic [PosFracBits-1:0] frac_q;
  logic [XWidth+24:0]    prod_x;
  logic [IdxWidth-1:0]   idx;
  logic [SvpWidth-1:0]   rom_lo, rom_hi;
  logic [DiffWidth+PosFracBits-1:0] prod_f;
  logic [TempWidth-1:0]  excess;
  logic [XFull-1:0]      x_full;

  // Stage 1: distance above the offset, scaled and clamped.
  always_comb begin
    excess = (XFull'(temp_i) > Offset) ? TempWidth'(XFull'(temp_i) - Offset) : '0;
    x_full = XFull'(excess) << Shift;
    x_d    = (x_full >= XFull'(XMax)) ? XMax : x_full[XWidth-1:0];
  end

  // Stage 2: divide by five through the reciprocal.
  assign prod_x = x_q * Recip;

  // Stage 3: table lookup of both neighbors.
  assign idx    = pos_q[PosWidth-1:PosFracBits];
  assign rom_lo = SvpRom[idx];
  assign rom_hi = SvpRom[idx + IdxWidth'(1)];

  // Stage 4: scale the step by the fraction.
  assign prod_f = diff_q * frac_q;

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    pos_q  <= prod_x[RecipShift +: PosWidth];
    lo_q   <= rom_lo;
    diff_q <= DiffWidth'(rom_hi - rom_lo);
    frac_q <= pos_q[PosFracBits-1:0];
    base_q <= lo_q;
    step_q <= prod_f[PosFracBits +: DiffWidth];
    svp_q  <= base_q + SvpWidth'(step_q);
  end

  assign svp_o = svp_q;

endmodule
`default_nettype wire

// File: rtl/core/rhd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhd_div
// Pipelined restoring divider: one quotient bit per stage, saturating at 1.0.
// ----------------------------------------------------------------------------
module rhd_div
  import rhd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic [SvpWidth-1:0]   num_i,
  input  wire logic [SvpWidth-1:0]   den_i,
  output logic      [RatioWidth-1:0] ratio_o
);

  logic [SvpWidth-1:0] rem_q [QuotBits];
  logic [SvpWidth-1:0] den_q [QuotBits];
  logic [QuotBits-1:0] quo_q [QuotBits];
  logic                sat_q [QuotBits];

  for (genvar k = 0; k < QuotBits; k++) begin : g_stage
    logic [SvpWidth-1:0] rem_in, den_in;
    logic [QuotBits-1:0] quo_in;
    logic                sat_in;
    logic [SvpWidth:0]   rem_sh;
    logic                bit_set;

    // The first stage sees the dividend directly; a ratio of 1.0 or more
    // saturates.
    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign sat_in = (num_i >= den_i);
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign sat_in = sat_q[k-1];
    end

    // One compare and subtract per stage.
    assign rem_sh  = {rem_in, 1'b0};
    assign bit_set = (rem_sh >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      rem_q[k] <= bit_set ? SvpWidth'(rem_sh - {1'b0, den_in}) : rem_sh[SvpWidth-1:0];
      den_q[k] <= den_in;
      quo_q[k] <= {quo_in[QuotBits-2:0], bit_set};
      sat_q[k] <= sat_in;
    end
  end

  assign ratio_o = sat_q[QuotBits-1] ? OneQ15 : {1'b0, quo_q[QuotBits-1]};

endmodule
`default_nettype wire

// File: rtl/core/relative_humidity_from_dewpoint.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// relative_humidity_from_dewpoint
// Relative humidity from air temperature and dewpoint via a pipelined table
// interpolation and a pipelined divider.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+-------------------------------------
//   input    | start_i, busy_o      | air_temp_k_i, air_temp_valid_i,
//            |                      | dew_temp_k_i, dew_temp_valid_i
//   result   | done_o (one cycle)   | humidity_ratio_o, humidity_valid_o
//
// One item enters per cycle; each result passes through five stages of
// interpolation, fifteen divider stages and the output register. busy_o
// stays low since the pipeline never stops; the receiver cannot stall.
// Reset clears only the internal valid bits and done_o, not humidity_valid_o.
// ----------------------------------------------------------------------------
module relative_humidity_from_dewpoint
  import rhd_pkg::*;
#(
  parameter int TEMP_FRAC_BITS = 7
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [TempWidth-1:0]  air_temp_k_i,
  input  wire logic                  air_temp_valid_i,
  input  wire logic [TempWidth-1:0]  dew_temp_k_i,
  input  wire logic                  dew_temp_valid_i,
  output logic                       done_o,
  output logic      [RatioWidth-1:0] humidity_ratio_o,
  output logic                       humidity_valid_o
);

  localparam int Depth = 5 + QuotBits;

  logic [SvpWidth-1:0]   svp_air, svp_dew;
  logic [RatioWidth-1:0] div_ratio;
  logic [Depth-1:0]      vld_q;
  rhd_tag_t              tag_q [Depth];
  rhd_tag_t              tag_d;
  logic                  done_q, valid_q;
  logic [RatioWidth-1:0] ratio_q, ratio_d;

  assign busy_o = 1'b0;

  rhd_svp #(.TEMP_FRAC_BITS(TEMP_FRAC_BITS)) u_svp_air (
    .clk_i (clk_i),
    .temp_i(air_temp_k_i),
    .svp_o (svp_air)
  );

  rhd_svp #(.TEMP_FRAC_BITS(TEMP_FRAC_BITS)) u_svp_dew (
    .clk_i (clk_i),
    .temp_i(dew_temp_k_i),
    .svp_o (svp_dew)
  );

  rhd_div u_div (
    .clk_i  (clk_i),
    .num_i  (svp_dew),
    .den_i  (svp_air),
    .ratio_o(div_ratio)
  );

  // Special cases are decided at entry and follow the item down the pipeline.
  assign tag_d.both_ok   = air_temp_valid_i & dew_temp_valid_i;
  assign tag_d.saturated = (air_temp_k_i <= dew_temp_k_i);

  // Valid bits, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[Depth-2:0], start_i};
      done_q <= vld_q[Depth-1];
    end
  end

  // Status tags travel beside the arithmetic.
  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_d;
    for (int k = 1; k < Depth; k++) begin
      tag_q[k] <= tag_q[k-1];
    end
  end

  // Result selection.
  always_comb begin
    if (!tag_q[Depth-1].both_ok) begin
      ratio_d = '0;
    end else if (tag_q[Depth-1].saturated) begin
      ratio_d = OneQ15;
    end else begin
      ratio_d = div_ratio;
    end
  end

  always_ff @(posedge clk_i) begin
    ratio_q <= ratio_d;
    valid_q <= tag_q[Depth-1].both_ok;
  end

  assign done_o           = done_q;
  assign humidity_ratio_o = ratio_q;
  assign humidity_valid_o = valid_q;

endmodule
`default_nettype wire
